// ===== rtl/nrm_pkg.sv =====
// Shared widths and payload types for the triangle unit normal pipeline.
// No dependencies; every rtl module imports this package.
package nrm_pkg;

   localparam int VTX_W   = 24;               // Q8.16 vertex coordinate
   localparam int EDGE_W  = VTX_W + 1;        // difference of two vertices
   localparam int PROD_W  = 2 * EDGE_W;       // edge by edge product
   localparam int CROSS_W = PROD_W;           // cross component, |C| < 2^49
   localparam int MAG_W   = CROSS_W - 1;      // magnitude of a cross component
   localparam int LO_W    = 25;               // low split of a magnitude
   localparam int HI_W    = MAG_W - LO_W;     // high split of a magnitude
   localparam int SQ_W    = 2 * MAG_W;        // square of one component
   localparam int SUM_W   = SQ_W + 2;         // sum of three squares
   localparam int ROOT_W  = SUM_W / 2;        // integer root of the sum
   localparam int REM_W   = ROOT_W + 2;       // root remainder
   localparam int FRAC_W  = 16;               // fraction bits of the results
   localparam int QUO_W   = FRAC_W + 1;       // quotient magnitude, <= 2^16
   localparam int DREM_W  = ROOT_W + 1;       // divider partial remainder
   localparam int NRM_W   = 18;               // Q1.16 normal component
   localparam int LEN_W   = ROOT_W - FRAC_W;  // Q18.16 length

   typedef logic signed [VTX_W-1:0]   vtx_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [NRM_W-1:0]   nrm_type;

   typedef struct packed {
      vtx_type x;
      vtx_type y;
      vtx_type z;
   } vtx_vec_type;

   typedef struct packed {
      cross_type x;
      cross_type y;
      cross_type z;
   } cross_vec_type;

endpackage

// ===== rtl/nrm_cross.sv =====
// Edge vectors and cross product of a triangle, three register stages.
// Depends on nrm_pkg.
module nrm_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  nrm_pkg::vtx_vec_type  in_first,
   input  nrm_pkg::vtx_vec_type  in_second,
   input  nrm_pkg::vtx_vec_type  in_pivot,
   output logic                  out_valid,
   input  logic                  out_ready,
   output nrm_pkg::cross_vec_type out_cross
);
   import nrm_pkg::*;

   localparam int NST = 3;

   logic                     v_ff [NST];
   logic                     rdy  [NST+1];
   logic signed [EDGE_W-1:0] p_ff [3];
   logic signed [EDGE_W-1:0] q_ff [3];
   logic signed [PROD_W-1:0] pr_ff [6];
   cross_type                c_ff [3];

   // ready ripples back through empty stages
   assign rdy[NST] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end
   endgenerate

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) v_ff[i] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NST; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // edges relative to the pivot
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         p_ff[0] <= EDGE_W'(in_first.x) - EDGE_W'(in_pivot.x);
         p_ff[1] <= EDGE_W'(in_first.y) - EDGE_W'(in_pivot.y);
         p_ff[2] <= EDGE_W'(in_first.z) - EDGE_W'(in_pivot.z);
         q_ff[0] <= EDGE_W'(in_second.x) - EDGE_W'(in_pivot.x);
         q_ff[1] <= EDGE_W'(in_second.y) - EDGE_W'(in_pivot.y);
         q_ff[2] <= EDGE_W'(in_second.z) - EDGE_W'(in_pivot.z);
      end
   end

   // six cross terms
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         pr_ff[0] <= p_ff[1] * q_ff[2];
         pr_ff[1] <= p_ff[2] * q_ff[1];
         pr_ff[2] <= p_ff[2] * q_ff[0];
         pr_ff[3] <= p_ff[0] * q_ff[2];
         pr_ff[4] <= p_ff[0] * q_ff[1];
         pr_ff[5] <= p_ff[1] * q_ff[0];
      end
   end

   // difference of the terms
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         c_ff[0] <= pr_ff[0] - pr_ff[1];
         c_ff[1] <= pr_ff[2] - pr_ff[3];
         c_ff[2] <= pr_ff[4] - pr_ff[5];
      end
   end

   assign in_ready    = rdy[0];
   assign out_valid   = v_ff[NST-1];
   assign out_cross.x = c_ff[0];
   assign out_cross.y = c_ff[1];
   assign out_cross.z = c_ff[2];

endmodule

// ===== rtl/nrm_square.sv =====
// Squared length of the cross product from split partial products.
// Four register stages; depends on nrm_pkg.
module nrm_square (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nrm_pkg::cross_vec_type in_cross,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nrm_pkg::cross_vec_type out_cross,
   output logic [nrm_pkg::SUM_W-1:0] out_sum,
   output logic                   out_degenerate
);
   import nrm_pkg::*;

   localparam int NST = 4;

   logic                v_ff [NST];
   logic                rdy  [NST+1];
   cross_vec_type       cr_ff [NST];
   cross_type           c_in [3];
   logic [MAG_W-1:0]    mag_ff [3];
   logic [2*HI_W-1:0]   hh_ff [3];
   logic [HI_W+LO_W-1:0] hl_ff [3];
   logic [2*LO_W-1:0]   ll_ff [3];
   logic [SQ_W-1:0]     sq_ff [3];
   logic [SUM_W-1:0]    sum_ff;
   logic                dg_ff;

   assign rdy[NST] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end
   endgenerate

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) v_ff[i] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NST; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // carry the cross vector along
   always_ff @(posedge clock) begin
      if (rdy[0]) cr_ff[0] <= in_cross;
      for (int i = 1; i < NST; i++) begin
         if (rdy[i]) cr_ff[i] <= cr_ff[i-1];
      end
   end

   assign c_in[0] = in_cross.x;
   assign c_in[1] = in_cross.y;
   assign c_in[2] = in_cross.z;

   // magnitudes, partial products, squares
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (rdy[0]) begin
            mag_ff[i] <= c_in[i][CROSS_W-1] ? MAG_W'(-c_in[i]) : MAG_W'(c_in[i]);
         end
         if (rdy[1]) begin
            hh_ff[i] <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][MAG_W-1:LO_W];
            hl_ff[i] <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][LO_W-1:0];
            ll_ff[i] <= mag_ff[i][LO_W-1:0] * mag_ff[i][LO_W-1:0];
         end
         if (rdy[2]) begin
            sq_ff[i] <= (SQ_W'(hh_ff[i]) << (2 * LO_W)) + (SQ_W'(hl_ff[i]) << (LO_W + 1))
                        + SQ_W'(ll_ff[i]);
         end
      end
   end

   // sum of squares; zero cross vector means a degenerate triangle
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         dg_ff  <= (cr_ff[2].x == '0) && (cr_ff[2].y == '0) && (cr_ff[2].z == '0);
      end
   end

   assign in_ready       = rdy[0];
   assign out_valid      = v_ff[NST-1];
   assign out_cross      = cr_ff[NST-1];
   assign out_sum        = sum_ff;
   assign out_degenerate = dg_ff;

endmodule

// ===== rtl/nrm_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on nrm_pkg.
module nrm_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nrm_pkg::cross_vec_type in_cross,
   input  logic [nrm_pkg::SUM_W-1:0] in_sum,
   input  logic                   in_degenerate,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nrm_pkg::cross_vec_type out_cross,
   output logic [nrm_pkg::ROOT_W-1:0] out_root,
   output logic                   out_degenerate
);
   import nrm_pkg::*;

   localparam int NST = ROOT_W;

   logic                v_ff    [NST];
   logic                rdy     [NST+1];
   logic [REM_W-1:0]    rem_ff  [NST];
   logic [ROOT_W-1:0]   root_ff [NST];
   logic [SUM_W-1:0]    rad_ff  [NST];
   cross_vec_type       cr_ff   [NST];
   logic                dg_ff   [NST];

   assign rdy[NST] = out_ready;

   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_st
         logic                 v_i;
         logic [REM_W-1:0]     rem_i;
         logic [ROOT_W-1:0]    root_i;
         logic [SUM_W-1:0]     rad_i;
         cross_vec_type        cr_i;
         logic                 dg_i;
         logic [REM_W+1:0]     r2;
         logic [REM_W+1:0]     trial;
         logic                 ge;

         if (k == 0) begin : g_first
            assign v_i    = in_valid;
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = in_sum;
            assign cr_i   = in_cross;
            assign dg_i   = in_degenerate;
         end else begin : g_next
            assign v_i    = v_ff[k-1];
            assign rem_i  = rem_ff[k-1];
            assign root_i = root_ff[k-1];
            assign rad_i  = rad_ff[k-1];
            assign cr_i   = cr_ff[k-1];
            assign dg_i   = dg_ff[k-1];
         end

         assign rdy[k] = !v_ff[k] || rdy[k+1];

         // bring down two radicand bits, try the next root bit
         assign r2    = {rem_i, rad_i[SUM_W-1 -: 2]};
         assign trial = (REM_W+2)'({root_i, 2'b01});
         assign ge    = r2 >= trial;

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= v_i;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               rem_ff[k]  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
               root_ff[k] <= {root_i[ROOT_W-2:0], ge};
               rad_ff[k]  <= rad_i << 2;
               cr_ff[k]   <= cr_i;
               dg_ff[k]   <= dg_i;
            end
         end
      end
   endgenerate

   assign in_ready       = rdy[0];
   assign out_valid      = v_ff[NST-1];
   assign out_cross      = cr_ff[NST-1];
   assign out_root       = root_ff[NST-1];
   assign out_degenerate = dg_ff[NST-1];

endmodule

// ===== rtl/nrm_div.sv =====
// Three-lane pipelined restoring divider forming C/|C| in Q1.16, plus output
// formatting and the result register. Depends on nrm_pkg.
module nrm_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nrm_pkg::cross_vec_type in_cross,
   input  logic [nrm_pkg::ROOT_W-1:0] in_root,
   input  logic                   in_degenerate,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nrm_pkg::nrm_type       out_normal_x,
   output nrm_pkg::nrm_type       out_normal_y,
   output nrm_pkg::nrm_type       out_normal_z,
   output logic [nrm_pkg::LEN_W-1:0] out_length,
   output logic                   out_degenerate
);
   import nrm_pkg::*;

   // magnitude stage, integer step, fraction steps, output register
   localparam int NST = FRAC_W + 3;
   localparam int OST = NST - 1;

   logic                v_ff   [NST];
   logic                rdy    [NST+1];
   logic [DREM_W-1:0]   num_ff [OST][3];
   logic [QUO_W-1:0]    quo_ff [OST][3];
   logic                neg_ff [OST][3];
   logic [ROOT_W-1:0]   len_ff [OST];
   logic                dg_ff  [OST];
   cross_type           c_in   [3];
   nrm_type             nrm_ff [3];
   logic [LEN_W-1:0]    olen_ff;
   logic                odg_ff;

   assign rdy[NST] = out_ready;
   assign c_in[0]  = in_cross.x;
   assign c_in[1]  = in_cross.y;
   assign c_in[2]  = in_cross.z;

   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end
   endgenerate

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) v_ff[i] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NST; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // take magnitudes and signs
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int l = 0; l < 3; l++) begin
            num_ff[0][l] <= c_in[l][CROSS_W-1] ? DREM_W'(-c_in[l]) : DREM_W'(c_in[l]);
            quo_ff[0][l] <= '0;
            neg_ff[0][l] <= c_in[l][CROSS_W-1];
         end
         len_ff[0] <= in_root;
         dg_ff[0]  <= in_degenerate;
      end
   end

   // integer quotient bit: magnitude never exceeds the length
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int l = 0; l < 3; l++) begin
            if (num_ff[0][l] >= DREM_W'(len_ff[0])) begin
               num_ff[1][l] <= num_ff[0][l] - DREM_W'(len_ff[0]);
               quo_ff[1][l] <= QUO_W'(1);
            end else begin
               num_ff[1][l] <= num_ff[0][l];
               quo_ff[1][l] <= '0;
            end
            neg_ff[1][l] <= neg_ff[0][l];
         end
         len_ff[1] <= len_ff[0];
         dg_ff[1]  <= dg_ff[0];
      end
   end

   // one fraction bit per stage
   generate
      for (k = 2; k < OST; k++) begin : g_frac
         logic [DREM_W-1:0] sh [3];
         logic              ge [3];
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign sh[l] = num_ff[k-1][l] << 1;
            assign ge[l] = sh[l] >= DREM_W'(len_ff[k-1]);
         end
         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               for (int l = 0; l < 3; l++) begin
                  num_ff[k][l] <= ge[l] ? sh[l] - DREM_W'(len_ff[k-1]) : sh[l];
                  quo_ff[k][l] <= {quo_ff[k-1][l][QUO_W-2:0], ge[l]};
                  neg_ff[k][l] <= neg_ff[k-1][l];
               end
               len_ff[k] <= len_ff[k-1];
               dg_ff[k]  <= dg_ff[k-1];
            end
         end
      end
   endgenerate

   // apply signs, zero everything for a degenerate triangle
   always_ff @(posedge clock) begin
      if (rdy[OST]) begin
         for (int l = 0; l < 3; l++) begin
            if (dg_ff[OST-1]) begin
               nrm_ff[l] <= '0;
            end else if (neg_ff[OST-1][l]) begin
               nrm_ff[l] <= -NRM_W'(quo_ff[OST-1][l]);
            end else begin
               nrm_ff[l] <= NRM_W'(quo_ff[OST-1][l]);
            end
         end
         olen_ff <= dg_ff[OST-1] ? '0 : len_ff[OST-1][ROOT_W-1:FRAC_W];
         odg_ff  <= dg_ff[OST-1];
      end
   end

   assign in_ready       = rdy[0];
   assign out_valid      = v_ff[NST-1];
   assign out_normal_x   = nrm_ff[0];
   assign out_normal_y   = nrm_ff[1];
   assign out_normal_z   = nrm_ff[2];
   assign out_length     = olen_ff;
   assign out_degenerate = odg_ff;

endmodule

// ===== rtl/triangle_unit_normal_core.sv =====
// Top level of the triangle unit normal pipeline.
// Depends on nrm_pkg, nrm_cross, nrm_square, nrm_sqrt and nrm_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  first, second, pivot vertex, Q8.16
//   rsp      out        rsp_valid/rsp_ready  unit normal Q1.16, length Q18.16, flag
//
// One triangle per clock is accepted until back pressure fills the pipe, which
// runs cross, square, one-bit-per-stage square root, then divide and output.
// Every stage holds a valid bit; a stage loads whenever it is empty or the one
// after it moves, so bubbles close up and the block keeps taking beats while a
// result waits. Synchronous reset clears only the valid bits.
module triangle_unit_normal_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nrm_pkg::vtx_type  req_first_x,
   input  nrm_pkg::vtx_type  req_first_y,
   input  nrm_pkg::vtx_type  req_first_z,
   input  nrm_pkg::vtx_type  req_second_x,
   input  nrm_pkg::vtx_type  req_second_y,
   input  nrm_pkg::vtx_type  req_second_z,
   input  nrm_pkg::vtx_type  req_pivot_x,
   input  nrm_pkg::vtx_type  req_pivot_y,
   input  nrm_pkg::vtx_type  req_pivot_z,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nrm_pkg::nrm_type  rsp_normal_x,
   output nrm_pkg::nrm_type  rsp_normal_y,
   output nrm_pkg::nrm_type  rsp_normal_z,
   output logic [nrm_pkg::LEN_W-1:0] rsp_cross_length,
   output logic              rsp_degenerate
);
   import nrm_pkg::*;

   vtx_vec_type      first_v, second_v, pivot_v;
   logic             cr_valid, cr_ready;
   cross_vec_type    cr_vec;
   logic             sq_valid, sq_ready;
   cross_vec_type    sq_vec;
   logic [SUM_W-1:0] sq_sum;
   logic             sq_dg;
   logic             rt_valid, rt_ready;
   cross_vec_type    rt_vec;
   logic [ROOT_W-1:0] rt_root;
   logic             rt_dg;

   assign first_v  = '{x: req_first_x,  y: req_first_y,  z: req_first_z};
   assign second_v = '{x: req_second_x, y: req_second_y, z: req_second_z};
   assign pivot_v  = '{x: req_pivot_x,  y: req_pivot_y,  z: req_pivot_z};

   nrm_cross u_cross (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_first(first_v), .in_second(second_v), .in_pivot(pivot_v),
      .out_valid(cr_valid), .out_ready(cr_ready), .out_cross(cr_vec)
   );

   nrm_square u_square (
      .clock(clock), .reset(reset),
      .in_valid(cr_valid), .in_ready(cr_ready), .in_cross(cr_vec),
      .out_valid(sq_valid), .out_ready(sq_ready), .out_cross(sq_vec),
      .out_sum(sq_sum), .out_degenerate(sq_dg)
   );

   nrm_sqrt u_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(sq_valid), .in_ready(sq_ready), .in_cross(sq_vec),
      .in_sum(sq_sum), .in_degenerate(sq_dg),
      .out_valid(rt_valid), .out_ready(rt_ready), .out_cross(rt_vec),
      .out_root(rt_root), .out_degenerate(rt_dg)
   );

   nrm_div u_div (
      .clock(clock), .reset(reset),
      .in_valid(rt_valid), .in_ready(rt_ready), .in_cross(rt_vec),
      .in_root(rt_root), .in_degenerate(rt_dg),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_normal_x(rsp_normal_x), .out_normal_y(rsp_normal_y),
      .out_normal_z(rsp_normal_z), .out_length(rsp_cross_length),
      .out_degenerate(rsp_degenerate)
   );

`ifndef SYNTHESIS
   // back pressure reaches the input only with a full pipe and a held result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the pipeline has room");

   // degenerate results carry zero normal and length
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == '0 && rsp_normal_y == '0
         && rsp_normal_z == '0 && rsp_cross_length == '0)
      else $error("degenerate result with nonzero payload");

   // a proper normal has at least one nonzero component
   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_normal_x != '0 || rsp_normal_y != '0
         || rsp_normal_z != '0)
      else $error("zero normal for a proper triangle");

   // components stay within the unit range
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= 18'sd65536 && rsp_normal_x >= -18'sd65536
         && rsp_normal_y <= 18'sd65536 && rsp_normal_y >= -18'sd65536
         && rsp_normal_z <= 18'sd65536 && rsp_normal_z >= -18'sd65536)
      else $error("normal component outside unit range");
`endif

endmodule
